[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the sleep level selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on every clock edge outside reset
`define SLS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check that a condition never holds outside reset
`define SLS_NEVER(name, clk, rstn, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define SLS_ASSERT(name, clk, rstn, prop, msg)
`define SLS_NEVER(name, clk, rstn, expr, msg)

`endif

`endif

[design/slsel_pkg.sv]
// ----------------------------------------------------------------------------
// slsel_pkg
// Shared types and constants of the sleep level selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slsel_pkg;

    localparam int MAX_LEVELS_DEF = 16;
    localparam int MASK_W         = 16;
    localparam int WORD_W         = 32;
    localparam int MODE_W         = 3;
    localparam int SLOT_W         = 4;
    localparam int COUNT_W        = 5;
    localparam int DEEP_W         = 33;
    localparam int BLEND_SHIFT    = 10;
    localparam int IN_DATA_W      = 224;
    localparam int OUT_DATA_W     = 72;
    localparam int CFG_ADDR_W     = 1;

    // Input kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_DEEP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_COUNT   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLLAPSE_MODE = 1'd1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_DEEP,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] entry_index;
        logic [MODE_W-1:0] entry_mode;
        logic [WORD_W-1:0] entry_latency;
        logic [WORD_W-1:0] entry_ss_power;
        logic [WORD_W-1:0] entry_energy;
        logic [WORD_W-1:0] entry_time_overhead;
        logic [MODE_W-1:0] query_mode;
        logic [WORD_W-1:0] latency_limit;
        logic [WORD_W-1:0] sleep_time;
        logic [MASK_W-1:0] available_mask;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] level_count;
        logic [MODE_W-1:0]  collapse_mode;
    } cfg_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] best_index;
        logic [WORD_W-1:0] best_power;
        logic [DEEP_W-1:0] deep_latency;
    } result_t;

endpackage

[design/slsel_div.sv]
// ----------------------------------------------------------------------------
// slsel_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsel_div
    import slsel_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvsr_reg, dvsr_next;
    logic [WORD_W:0]   trial;
    logic              fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? WORD_W'(trial - {1'b0, dvsr_reg}) : trial[WORD_W-1:0];
            quo_next  = {quo_reg[WORD_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/slsel_front.sv]
// ----------------------------------------------------------------------------
// slsel_front
// Accepts input transfers, decodes the kind and queues items for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsel_front
    import slsel_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output item_t                q_item
);

    localparam int DEPTH = 2;

    item_t       slot_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push, pop;
    item_t       dec_item;

    // Decode the kind and unpack the fields
    always_comb begin
        unique case (s_axis_tuser)
            KIND_WRITE: dec_item.op = OP_WRITE;
            KIND_QUERY: dec_item.op = OP_QUERY;
            KIND_DEEP:  dec_item.op = OP_DEEP;
            default:    dec_item.op = OP_NONE;
        endcase
        dec_item.entry_index         = s_axis_tdata[3:0];
        dec_item.entry_mode          = s_axis_tdata[6:4];
        dec_item.entry_latency       = s_axis_tdata[38:7];
        dec_item.entry_ss_power      = s_axis_tdata[70:39];
        dec_item.entry_energy        = s_axis_tdata[102:71];
        dec_item.entry_time_overhead = s_axis_tdata[134:103];
        dec_item.query_mode          = s_axis_tdata[137:135];
        dec_item.latency_limit       = s_axis_tdata[169:138];
        dec_item.sleep_time          = s_axis_tdata[201:170];
        dec_item.available_mask      = s_axis_tdata[217:202];
    end

    assign s_axis_tready = fill_reg != 2'(DEPTH);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = fill_reg != 2'd0;
    assign pop           = q_valid && q_ready;
    assign q_item        = slot_reg[rd_ptr_reg];

    // Advance the queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

[design/slsel_back.sv]
// ----------------------------------------------------------------------------
// slsel_back
// Level table and the sequencer that walks it for queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsel_back
    import slsel_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W = $clog2(MAX_LEVELS + 1);
    localparam int CMP_W = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_DIVA0,
        S_DIVA,
        S_DIVE,
        S_CMP,
        S_DONE
    } state_t;

    // Level table
    logic [MODE_W-1:0] mem_mode [MAX_LEVELS];
    logic [WORD_W-1:0] mem_lat  [MAX_LEVELS];
    logic [WORD_W-1:0] mem_ss   [MAX_LEVELS];
    logic [WORD_W-1:0] mem_en   [MAX_LEVELS];
    logic [WORD_W-1:0] mem_to   [MAX_LEVELS];

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              have_reg, have_next;
    logic [CNT_W-1:0]  best_idx_reg, best_idx_next;
    logic [WORD_W-1:0] best_pwr_reg, best_pwr_next;
    logic [MODE_W-1:0] best_mode_reg, best_mode_next;
    logic [WORD_W-1:0] best_lat_reg, best_lat_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] diff_reg, diff_next;
    logic [WORD_W-1:0] pwr_reg, pwr_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [MODE_W-1:0] rd_mode_reg;
    logic [WORD_W-1:0] rd_lat_reg, rd_ss_reg, rd_en_reg, rd_to_reg;

    logic [CMP_W-1:0]  lc_ext, nmax, n_used, cnt_ext;
    logic              last, avail, mem_we;
    logic              div_start, div_done;
    logic [WORD_W-1:0] div_dividend, div_q;
    logic [MODE_W-1:0] cur_mode;
    logic [WORD_W-1:0] cur_lat;
    logic [MODE_W-1:0] pick_mode;
    logic [WORD_W-1:0] pick_lat;

    slsel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (item_reg.sleep_time),
        .done     (div_done),
        .quotient (div_q)
    );

    // Levels in use, clamped to the table depth
    assign lc_ext  = CMP_W'(cfg.level_count);
    assign nmax    = CMP_W'(MAX_LEVELS);
    assign n_used  = (lc_ext > nmax) ? nmax : lc_ext;
    assign cnt_ext = CMP_W'(cnt_reg);
    assign last    = (cnt_ext + 1'b1) >= n_used;
    assign avail   = (cnt_ext < CMP_W'(MASK_W)) &&
                     item_reg.available_mask[cnt_ext[3:0]];
    assign mem_we  = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_WRITE) &&
                     (CMP_W'(q_item.entry_index) < nmax);

    // Deep idle tracking: the first level seeds the running best
    always_comb begin
        cur_mode  = (cnt_reg == '0) ? rd_mode_reg : best_mode_reg;
        cur_lat   = (cnt_reg == '0) ? rd_lat_reg : best_lat_reg;
        pick_mode = cur_mode;
        pick_lat  = cur_lat;
        if (avail && rd_mode_reg == cfg.collapse_mode) begin
            if (cur_mode != cfg.collapse_mode) begin
                pick_mode = rd_mode_reg;
                pick_lat  = rd_lat_reg;
            end
            if (rd_lat_reg < pick_lat) begin
                pick_mode = rd_mode_reg;
                pick_lat  = rd_lat_reg;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_pwr_next  = best_pwr_reg;
        best_mode_next = best_mode_reg;
        best_lat_next  = best_lat_reg;
        prod_next      = prod_reg;
        diff_next      = diff_reg;
        pwr_next       = pwr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        q_ready        = 1'b0;
        div_start      = 1'b0;
        div_dividend   = rd_en_reg;

        // Drop the result once it is taken
        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next = q_item;
                    cnt_next  = '0;
                    have_next = 1'b0;
                    if ((q_item.op == OP_QUERY || q_item.op == OP_DEEP) &&
                        n_used != '0) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (item_reg.op == OP_DEEP) begin
                    have_next      = 1'b1;
                    best_mode_next = pick_mode;
                    best_lat_next  = pick_lat;
                    state_next     = last ? S_DONE : S_READ;
                    cnt_next       = last ? cnt_reg : cnt_reg + 1'b1;
                end else if (!avail || rd_mode_reg != item_reg.query_mode ||
                             item_reg.latency_limit < rd_lat_reg) begin
                    state_next = last ? S_DONE : S_READ;
                    cnt_next   = last ? cnt_reg : cnt_reg + 1'b1;
                end else if (item_reg.sleep_time <= WORD_W'(1)) begin
                    pwr_next   = rd_en_reg;
                    state_next = S_CMP;
                end else if (item_reg.sleep_time <= rd_to_reg) begin
                    diff_next  = '0;
                    div_start  = 1'b1;
                    state_next = S_DIVE;
                end else if ((item_reg.sleep_time >> BLEND_SHIFT) > rd_to_reg) begin
                    pwr_next   = rd_ss_reg;
                    state_next = S_CMP;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = WORD_W'(rd_to_reg * rd_ss_reg);
                state_next = S_DIVA0;
            end
            S_DIVA0: begin
                div_dividend = prod_reg;
                div_start    = 1'b1;
                state_next   = S_DIVA;
            end
            S_DIVA: begin
                if (div_done) begin
                    diff_next  = rd_ss_reg - div_q;
                    div_start  = 1'b1;
                    state_next = S_DIVE;
                end
            end
            S_DIVE: begin
                if (div_done) begin
                    pwr_next   = diff_reg + div_q;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (!have_reg || best_pwr_reg >= pwr_reg) begin
                    have_next     = 1'b1;
                    best_idx_next = cnt_reg;
                    best_pwr_next = pwr_reg;
                end
                state_next = last ? S_DONE : S_READ;
                cnt_next   = last ? cnt_reg : cnt_reg + 1'b1;
            end
            S_DONE: begin
                if (!res_valid_reg || res_ready) begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    if (have_reg && item_reg.op == OP_QUERY) begin
                        res_next.found      = 1'b1;
                        res_next.best_index = SLOT_W'(best_idx_reg);
                        res_next.best_power = best_pwr_reg;
                    end
                    if (have_reg && item_reg.op == OP_DEEP) begin
                        res_next.deep_latency = {1'b0, best_lat_reg} - DEEP_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            have_reg      <= have_next;
            cnt_reg       <= cnt_next;
        end
        item_reg      <= item_next;
        best_idx_reg  <= best_idx_next;
        best_pwr_reg  <= best_pwr_next;
        best_mode_reg <= best_mode_next;
        best_lat_reg  <= best_lat_next;
        prod_reg      <= prod_next;
        diff_reg      <= diff_next;
        pwr_reg       <= pwr_next;
        res_reg       <= res_next;
    end

    // Table write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_mode[IDX_W'(q_item.entry_index)] <= q_item.entry_mode;
            mem_lat[IDX_W'(q_item.entry_index)]  <= q_item.entry_latency;
            mem_ss[IDX_W'(q_item.entry_index)]   <= q_item.entry_ss_power;
            mem_en[IDX_W'(q_item.entry_index)]   <= q_item.entry_energy;
            mem_to[IDX_W'(q_item.entry_index)]   <= q_item.entry_time_overhead;
        end
        if (state_reg == S_READ) begin
            rd_mode_reg <= mem_mode[cnt_reg[IDX_W-1:0]];
            rd_lat_reg  <= mem_lat[cnt_reg[IDX_W-1:0]];
            rd_ss_reg   <= mem_ss[cnt_reg[IDX_W-1:0]];
            rd_en_reg   <= mem_en[cnt_reg[IDX_W-1:0]];
            rd_to_reg   <= mem_to[cnt_reg[IDX_W-1:0]];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/sleep_level_selector.sv]
// ----------------------------------------------------------------------------
// sleep_level_selector
// Sleep level table with lowest-power and deep-idle latency queries.
// ----------------------------------------------------------------------------
// Every input transfer gives one result transfer. A query walks the levels in
// use one at a time through a single-port table read; a level whose sleep time
// lies between its overhead and 1024 times it takes one multiply and two divides
// on the shared divider. Items are handled one at a time; a two-entry input
// queue and an output register let both sides stall on their own. Write
// configuration only while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sleep_level_selector
    import slsel_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, entry_mode, entry_latency, entry_ss_power, entry_energy,
    // entry_time_overhead, query_mode, latency_limit, sleep_time, available_mask
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found, best_index, best_power, deep_latency
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cfg_t    cfg_reg;
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t res;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LEVEL_COUNT:   cfg_reg.level_count   <= cfg_wdata;
                REG_COLLAPSE_MODE: cfg_reg.collapse_mode <= cfg_wdata[MODE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    slsel_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    slsel_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result fields
    assign m_axis_tdata = {2'b00, res.deep_latency, res.best_power,
                           res.best_index, res.found};

    `SLS_ASSERT(a_found_no_deep, aclk, aresetn, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[69:37] == '0), "query result carries a deep latency")
    `SLS_ASSERT(a_miss_is_zero, aclk, aresetn, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[36:1] == '0), "missed query carries index or power")
    `SLS_NEVER(a_pop_empty, aclk, aresetn, q_ready && !q_valid && s_axis_tready == 1'b0, "input stalled while queue is empty")

endmodule

[tb/sleep_level_checker.sv]
// ----------------------------------------------------------------------------
// sleep_level_checker
// Watches the config port and both streams of the sleep level selector, keeps
// a shadow of the level table, predicts one result per input transfer and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sleep_level_checker
    import slsel_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    pending,
    output int                    fail_count
);

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] best_index;
        logic [WORD_W-1:0] best_power;
        logic [DEEP_W-1:0] deep_latency;
    } selection_t;

    // Shadow of the level table and the registers
    logic [MODE_W-1:0] tbl_mode     [MAX_LEVELS_DEF];
    logic [WORD_W-1:0] tbl_latency  [MAX_LEVELS_DEF];
    logic [WORD_W-1:0] tbl_ss_power [MAX_LEVELS_DEF];
    logic [WORD_W-1:0] tbl_energy   [MAX_LEVELS_DEF];
    logic [WORD_W-1:0] tbl_overhead [MAX_LEVELS_DEF];
    logic [COUNT_W-1:0] shadow_count;
    logic [MODE_W-1:0]  shadow_collapse;

    selection_t expected_selections[$];

    initial begin
        for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
            tbl_mode[i]     = '0;
            tbl_latency[i]  = '0;
            tbl_ss_power[i] = '0;
            tbl_energy[i]   = '0;
            tbl_overhead[i] = '0;
        end
    end

    // Power of one level for sleep time t
    function automatic logic [WORD_W-1:0] level_power(int lvl, logic [WORD_W-1:0] t);
        logic [WORD_W-1:0] o;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] e;
        logic [WORD_W-1:0] prod;
        o = tbl_overhead[lvl];
        s = tbl_ss_power[lvl];
        e = tbl_energy[lvl];
        if (t <= 1) return e;
        if (t <= o) return e / t;
        if ((t >> BLEND_SHIFT) > o) return s;
        prod = o * s;
        return s - prod / t + e / t;
    endfunction

    // Apply one input transfer to the shadow table and predict its result
    function automatic selection_t predict_selection(logic [1:0] kind,
                                                     logic [IN_DATA_W-1:0] d);
        selection_t r;
        int n;
        int best;
        logic have;
        logic [WORD_W-1:0] pwr;
        logic [SLOT_W-1:0] idx;
        logic [MODE_W-1:0] qmode;
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] t;
        logic [MASK_W-1:0] mask;
        r     = '0;
        n     = (shadow_count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(shadow_count);
        idx   = d[3:0];
        qmode = d[137:135];
        limit = d[169:138];
        t     = d[201:170];
        mask  = d[217:202];
        best  = 0;
        have  = 1'b0;
        case (kind)
            KIND_WRITE: begin
                tbl_mode[idx]     = d[6:4];
                tbl_latency[idx]  = d[38:7];
                tbl_ss_power[idx] = d[70:39];
                tbl_energy[idx]   = d[102:71];
                tbl_overhead[idx] = d[134:103];
            end
            KIND_QUERY: begin
                for (int i = 0; i < n; i++) begin
                    if (!mask[i] || tbl_mode[i] != qmode || limit < tbl_latency[i])
                        continue;
                    pwr = level_power(i, t);
                    // later level wins a tie
                    if (!have || r.best_power >= pwr) begin
                        have         = 1'b1;
                        r.best_index = SLOT_W'(i);
                        r.best_power = pwr;
                    end
                end
                r.found = have;
            end
            KIND_DEEP: begin
                if (n != 0) begin
                    for (int i = 0; i < n; i++) begin
                        if (!mask[i] || tbl_mode[i] != shadow_collapse) continue;
                        if (tbl_mode[best] != shadow_collapse) best = i;
                        if (tbl_latency[i] < tbl_latency[best]) best = i;
                    end
                    r.deep_latency = {1'b0, tbl_latency[best]} - 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %0t: %s expected 0x%0h got 0x%0h", $realtime, name, exp_v, act_v);
    endfunction

    // Track config writes, predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        selection_t exp_sel;
        selection_t act_sel;
        if (!aresetn) begin
            shadow_count    = '0;
            shadow_collapse = '0;
            expected_selections.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_LEVEL_COUNT) shadow_count = cfg_wdata;
                else if (cfg_addr == REG_COLLAPSE_MODE) shadow_collapse = cfg_wdata[MODE_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_selections.push_back(predict_selection(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                act_sel.found        = m_axis_tdata[0];
                act_sel.best_index   = m_axis_tdata[4:1];
                act_sel.best_power   = m_axis_tdata[36:5];
                act_sel.deep_latency = m_axis_tdata[69:37];
                if (expected_selections.size() == 0) begin
                    report_field("unexpected result", 64'd0, 64'(act_sel));
                end else begin
                    exp_sel = expected_selections.pop_front();
                    if (act_sel.found != exp_sel.found)
                        report_field("found", 64'(exp_sel.found), 64'(act_sel.found));
                    if (act_sel.best_index != exp_sel.best_index)
                        report_field("best_index", 64'(exp_sel.best_index),
                                     64'(act_sel.best_index));
                    if (act_sel.best_power != exp_sel.best_power)
                        report_field("best_power", 64'(exp_sel.best_power),
                                     64'(act_sel.best_power));
                    if (act_sel.deep_latency != exp_sel.deep_latency)
                        report_field("deep_latency", 64'(exp_sel.deep_latency),
                                     64'(act_sel.deep_latency));
                end
            end
        end
        pending = expected_selections.size();
    end

endmodule

[tb/sleep_level_selector_tb.sv]
// ----------------------------------------------------------------------------
// sleep_level_selector_tb
// Fills the level table, runs directed queries on power regions, ties and
// deep-idle latency, then random write/query/deep traffic over several
// register settings with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sleep_level_selector_tb;
    import slsel_pkg::*;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [COUNT_W-1:0]    cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    pending;
    int                    fail_count;

    int burst_left;
    int rx_hold = 0;
    int rx_mode = 0;

    always #2 aclk = ~aclk;

    sleep_level_selector dut (.*);

    sleep_level_checker checker_i (.*);

    // Receiver stall pattern: free-running, light and heavy stretches
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_hold = $urandom_range(20, 300);
        end else begin
            rx_hold--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [COUNT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Present one item and hold it until the transfer
    task automatic send_item(logic [1:0] kind, logic [3:0] idx, logic [2:0] mode,
                             logic [31:0] lat, logic [31:0] ss, logic [31:0] en,
                             logic [31:0] ov, logic [2:0] qm, logic [31:0] lim,
                             logic [31:0] st, logic [15:0] mask);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, mask, st, lim, qm, ov, en, ss, lat, mode, idx};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1000);
            1:       return $urandom_range(1000, 2000000);
            2:       return $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
    endfunction

    // Random traffic in bursts; most items are queries against a live table
    task automatic random_traffic(int count, logic pause_midway);
        int sel;
        burst_left = $urandom_range(1, 12);
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 4)
                send_item(KIND_WRITE, 4'($urandom), pick_mode(), pick_word(), $urandom,
                          pick_word(), pick_word(), 3'd0, 32'd0, 32'd0, 16'd0);
            else if (sel < 15)
                send_item(KIND_QUERY, 4'($urandom), 3'($urandom), $urandom, $urandom,
                          $urandom, $urandom, pick_mode(),
                          ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : pick_word(),
                          pick_word(), 16'($urandom));
            else if (sel < 19)
                send_item(KIND_DEEP, 4'($urandom), 3'($urandom), $urandom, $urandom,
                          $urandom, $urandom, 3'($urandom), $urandom, $urandom,
                          16'($urandom));
            else
                send_item(2'(OP_NONE), 4'($urandom), 3'($urandom), $urandom, $urandom,
                          $urandom, $urandom, 3'($urandom), $urandom, $urandom,
                          16'($urandom));
            if (pause_midway && k == count / 2) drain_results();
            burst_left--;
            if (burst_left <= 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            end
        end
        drain_results();
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] count, logic [2:0] cmode, int items);
        reg_write(REG_LEVEL_COUNT, count);
        reg_write(REG_COLLAPSE_MODE, {2'd0, cmode});
        random_traffic(items, 1'b0);
    endtask

    initial begin
        logic [2:0]  mode;
        logic [31:0] lat;
        logic [31:0] en;
        logic [31:0] ov;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reg_write(REG_LEVEL_COUNT, 5'd16);
        reg_write(REG_COLLAPSE_MODE, 5'd0);

        // Fill every slot; levels 3 and 7 share mode and energy
        for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
            mode = (i == 3 || i == 7) ? 3'd5 : 3'(i % 4);
            lat  = (i == 15) ? 32'hFFFF_FFFF : 32'(i * 10);
            en   = (i == 3 || i == 7) ? 32'd100 : ((i == 14) ? 32'hFFFF_FFFF : $urandom);
            ov   = (i == 13) ? 32'hFFFF_FFFF : 32'(i * 3);
            send_item(KIND_WRITE, 4'(i), mode, lat, $urandom, en, ov,
                      3'd0, 32'd0, 32'd0, 16'd0);
        end
        // Sleep time zero with a tie, one, max, blended; two with no match; deep; unknown kind
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd5, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd1, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd2, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd1, 32'hFFFF_FFFF, 32'd20, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd3, 32'd0, 32'd500, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 3'd0, 0, 0, 0, 0, 3'd1, 32'hFFFF_FFFF, 32'd9, 16'h0000);
        send_item(KIND_DEEP, 4'd0, 3'd0, 0, 0, 0, 0, 3'd0, 32'd0, 32'd0, 16'hFFFF);
        send_item(KIND_DEEP, 4'd0, 3'd0, 0, 0, 0, 0, 3'd0, 32'd0, 32'd0, 16'h0000);
        send_item(2'(OP_NONE), 4'hF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        drain_results();

        // Random phases over the register range, with a mid-phase drain
        reg_write(REG_LEVEL_COUNT, 5'd16);
        reg_write(REG_COLLAPSE_MODE, 5'd1);
        random_traffic(150, 1'b1);
        run_phase(5'd0, 3'd3, 30);
        run_phase(5'd31, 3'd7, 150);
        run_phase(5'd1, 3'd2, 40);
        run_phase(5'($urandom_range(2, 15)), 3'($urandom), 170);

        repeat (1200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("sleep_level_selector_tb: done, clean");
        else
            $display("sleep_level_selector_tb: done, errors");
        $finish;
    end

    // Run limit
    initial begin
        #12000000;
        $display("sleep_level_selector_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/slsel_pkg.sv
design/slsel_div.sv
design/slsel_front.sv
design/slsel_back.sv
design/sleep_level_selector.sv
tb/sleep_level_checker.sv
tb/sleep_level_selector_tb.sv
